### sv/scmp_pkg.sv
// Shared types and constants for the SMTP command line parser.
// No dependencies; the core and scmp_fsm refer to this package by scoped names.

package scmp_pkg;

    // parser state codes, also reported as state_code
    localparam logic [2:0] ST_VFIRST  = 3'd0;
    localparam logic [2:0] ST_VSIMPLE = 3'd1;
    localparam logic [2:0] ST_VCOLON  = 3'd2;
    localparam logic [2:0] ST_ARG     = 3'd3;
    localparam logic [2:0] ST_AWAITLF = 3'd4;
    localparam logic [2:0] ST_DONE    = 3'd5;
    localparam logic [2:0] ST_ERROR   = 3'd6;

    // store select codes
    localparam logic [1:0] SEL_NONE = 2'd0;
    localparam logic [1:0] SEL_VERB = 2'd1;
    localparam logic [1:0] SEL_ARG  = 2'd2;

    // request types
    localparam logic REQ_FEED    = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

    // characters of interest
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UP_M  = 8'h4D;
    localparam logic [7:0] CH_LO_M  = 8'h6D;
    localparam logic [7:0] CH_UP_R  = 8'h52;
    localparam logic [7:0] CH_LO_R  = 8'h72;

    typedef struct packed {
        logic [2:0] state_code;
        logic [1:0] store_sel;
        logic [7:0] store_index;
        logic [7:0] store_byte;
        logic       finished;
        logic       errored;
    } t_result;

endpackage

### sv/scmp_req_if.sv
// Request channel of the SMTP command line parser: valid/ready plus one item.
// Depends on nothing.

interface scmp_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] in_byte;

    modport source (output valid, output req_type, output in_byte, input ready);
    modport sink   (input valid, input req_type, input in_byte, output ready);
endinterface

### sv/scmp_res_if.sv
// Result channel of the SMTP command line parser: valid/ready plus one result.
// Depends on nothing.

interface scmp_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] state_code;
    logic [1:0] store_sel;
    logic [7:0] store_index;
    logic [7:0] store_byte;
    logic       finished;
    logic       errored;

    modport source (output valid, output state_code, output store_sel, output store_index,
                    output store_byte, output finished, output errored, input ready);
    modport sink   (input valid, input state_code, input store_sel, input store_index,
                    input store_byte, input finished, input errored, output ready);
endinterface

### sv/smtp_command_line_parser_core.sv
// SMTP command line parser, top level.
// Path: a request beat is held in the input register, then moves into the result register.
// Throughput: one beat per cycle while o_res.ready does not stall the result register; the
// parser state updates as a beat moves into the result register, so the state loop sets the rate.
// Reset (synchronous, active low): pipeline empty, state verbfirst, both positions zero.
// Depends on scmp_pkg, scmp_req_if, scmp_res_if and scmp_fsm.

module smtp_command_line_parser_core #(
    parameter int VERB_BYTES = 16,
    parameter int ARG_BYTES  = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    scmp_req_if.sink    i_req,
    scmp_res_if.source  o_res
);
    logic              r_in_valid;
    logic              r_req_type;
    logic [7:0]        r_in_byte;
    logic              r_out_valid;
    scmp_pkg::t_result r_out;
    scmp_pkg::t_result step_result;
    logic              advance;

    // move the held beat into the result register when that slot is free or is being taken
    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || advance;

    scmp_fsm #(
        .VERB_BYTES (VERB_BYTES),
        .ARG_BYTES  (ARG_BYTES)
    ) u_fsm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_req_type (r_req_type),
        .i_in_byte  (r_in_byte),
        .o_result   (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req_type <= i_req.req_type;
            r_in_byte  <= i_req.in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_result;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.state_code  = r_out.state_code;
    assign o_res.store_sel   = r_out.store_sel;
    assign o_res.store_index = r_out.store_index;
    assign o_res.store_byte  = r_out.store_byte;
    assign o_res.finished    = r_out.finished;
    assign o_res.errored     = r_out.errored;
endmodule

### sv/scmp_fsm.sv
// Parser state, verb and argument positions, and the per-byte transition.
// Depends on scmp_pkg.

module scmp_fsm #(
    parameter int VERB_BYTES = 16,
    parameter int ARG_BYTES  = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  logic              i_req_type,
    input  logic [7:0]        i_in_byte,
    output scmp_pkg::t_result o_result
);
    localparam int VW = $clog2(VERB_BYTES);
    localparam int AW = $clog2(ARG_BYTES);
    localparam logic [VW-1:0] VERB_LAST = VW'(VERB_BYTES - 1);
    localparam logic [AW-1:0] ARG_LAST  = AW'(ARG_BYTES - 1);

    logic [2:0]    r_state, n_state;
    logic [VW-1:0] r_verb_count, n_verb_count;
    logic [AW-1:0] r_arg_count, n_arg_count;
    logic [1:0]    sel;
    logic [7:0]    wr_byte;
    logic [7:0]    verb_pos, arg_pos;
    logic [7:0]    wr_index;
    logic          is_delim, verb_room;
    logic          colon_verb;

    // store index carries the low 8 bits of a position
    assign verb_pos  = 8'(r_verb_count);
    assign arg_pos   = 8'(r_arg_count);
    assign verb_room = (r_verb_count < VERB_LAST);
    assign colon_verb = (i_in_byte == scmp_pkg::CH_UP_M) || (i_in_byte == scmp_pkg::CH_LO_M) ||
                        (i_in_byte == scmp_pkg::CH_UP_R) || (i_in_byte == scmp_pkg::CH_LO_R);
    assign is_delim  = (r_state == scmp_pkg::ST_VCOLON) ? (i_in_byte == scmp_pkg::CH_COLON)
                                                        : (i_in_byte == scmp_pkg::CH_SPACE);

    always_comb begin
        n_state      = r_state;
        n_verb_count = r_verb_count;
        n_arg_count  = r_arg_count;
        sel          = scmp_pkg::SEL_NONE;
        wr_byte      = 8'd0;
        if (i_req_type == scmp_pkg::REQ_RESTART) begin
            n_state      = scmp_pkg::ST_VFIRST;
            n_verb_count = '0;
            n_arg_count  = '0;
        end else begin
            case (r_state)
                scmp_pkg::ST_VFIRST: begin
                    sel = scmp_pkg::SEL_VERB;
                    if (i_in_byte == scmp_pkg::CH_CR) begin
                        n_state = scmp_pkg::ST_AWAITLF;
                    end else begin
                        wr_byte      = i_in_byte;
                        n_verb_count = r_verb_count + 1'b1;
                        n_state      = colon_verb ? scmp_pkg::ST_VCOLON : scmp_pkg::ST_VSIMPLE;
                    end
                end
                scmp_pkg::ST_VSIMPLE, scmp_pkg::ST_VCOLON: begin
                    if (is_delim || i_in_byte == scmp_pkg::CH_CR) begin
                        sel     = scmp_pkg::SEL_VERB;
                        n_state = (i_in_byte == scmp_pkg::CH_CR) ? scmp_pkg::ST_AWAITLF
                                                                 : scmp_pkg::ST_ARG;
                    end else if (verb_room) begin
                        sel          = scmp_pkg::SEL_VERB;
                        wr_byte      = i_in_byte;
                        n_verb_count = r_verb_count + 1'b1;
                    end
                end
                scmp_pkg::ST_ARG: begin
                    // skip leading spaces; drop bytes once the argument is full
                    if (i_in_byte == scmp_pkg::CH_SPACE && r_arg_count == '0) begin
                        sel = scmp_pkg::SEL_NONE;
                    end else if (i_in_byte == scmp_pkg::CH_CR) begin
                        sel     = scmp_pkg::SEL_ARG;
                        n_state = scmp_pkg::ST_AWAITLF;
                    end else if (r_arg_count < ARG_LAST) begin
                        sel         = scmp_pkg::SEL_ARG;
                        wr_byte     = i_in_byte;
                        n_arg_count = r_arg_count + 1'b1;
                    end
                end
                scmp_pkg::ST_AWAITLF: begin
                    n_state = (i_in_byte == scmp_pkg::CH_LF) ? scmp_pkg::ST_DONE
                                                             : scmp_pkg::ST_ERROR;
                end
                scmp_pkg::ST_DONE, scmp_pkg::ST_ERROR: begin
                    n_state = r_state;
                end
                default: begin
                    n_state = scmp_pkg::ST_ERROR;
                end
            endcase
        end
    end

    always_comb begin
        case (sel)
            scmp_pkg::SEL_VERB: wr_index = verb_pos;
            scmp_pkg::SEL_ARG:  wr_index = arg_pos;
            default:            wr_index = 8'd0;
        endcase
    end

    assign o_result.state_code  = n_state;
    assign o_result.store_sel   = sel;
    assign o_result.store_index = wr_index;
    assign o_result.store_byte  = wr_byte;
    assign o_result.finished    = (n_state == scmp_pkg::ST_DONE) ||
                                  (n_state == scmp_pkg::ST_ERROR);
    assign o_result.errored     = (n_state == scmp_pkg::ST_ERROR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= scmp_pkg::ST_VFIRST;
            r_verb_count <= '0;
            r_arg_count  <= '0;
        end else if (i_advance) begin
            r_state      <= n_state;
            r_verb_count <= n_verb_count;
            r_arg_count  <= n_arg_count;
        end
    end
endmodule
